>>> rtl/core/ete_pkg.sv
// Shared types, constants and helper functions for the Euler angle to
// quaternion unit. No dependencies.

package ete_pkg;

	localparam int ANGLE_BITS   = 16;
	localparam int FRAC_BITS    = 15;
	localparam int CORDIC_STEPS = 30;
	localparam int CORDIC_LAT   = CORDIC_STEPS + 1;

	localparam int ANGLE_W = 16;
	localparam int OUT_W   = 16;
	localparam int SC_W    = 32;
	localparam int Z_W     = 32;
	localparam int PROD_W  = 64;
	localparam int STEP_W  = $clog2(CORDIC_STEPS);

	localparam int HALF_SHIFT = 31 - ANGLE_BITS;
	localparam int Q30_SHIFT  = 30;
	localparam int OUT_SHIFT  = 60 - FRAC_BITS;

	typedef logic [ANGLE_W-1:0]        angle_t;
	typedef logic signed [SC_W-1:0]    sc_t;
	typedef logic signed [Z_W-1:0]     zang_t;
	typedef logic signed [PROD_W-1:0]  prod_t;
	typedef logic signed [OUT_W-1:0]   q15_t;

	typedef struct packed {
		sc_t s;
		sc_t c;
	} sincos_t;

	localparam sc_t   CORDIC_GAIN  = 32'sd652032874;
	localparam zang_t QUARTER_TURN = 32'sd1073741824;
	localparam logic [31:0] ANGLE_MASK = 32'((64'd1 << ANGLE_BITS) - 64'd1);

	localparam prod_t Q30_HALF = 64'sd536870912;
	localparam prod_t OUT_HALF = $signed(64'd1 << (OUT_SHIFT - 1));
	localparam prod_t OUT_MAX  = 64'sd32767;
	localparam prod_t OUT_MIN  = -64'sd32768;

	// 1.0 after rounding and saturation
	localparam q15_t IDENT_W = (FRAC_BITS >= OUT_W - 1) ? q15_t'(OUT_MAX)
		: q15_t'(64'd1 << FRAC_BITS);

	// atan(2^-i), 2^32 units per full turn
	function automatic zang_t atan_turn(input logic [STEP_W-1:0] idx);
		zang_t a;
		case (idx)
			5'd0:  a = 32'sd536870912;
			5'd1:  a = 32'sd316933406;
			5'd2:  a = 32'sd167458907;
			5'd3:  a = 32'sd85004756;
			5'd4:  a = 32'sd42667331;
			5'd5:  a = 32'sd21354465;
			5'd6:  a = 32'sd10679838;
			5'd7:  a = 32'sd5340245;
			5'd8:  a = 32'sd2670163;
			5'd9:  a = 32'sd1335087;
			5'd10: a = 32'sd667544;
			5'd11: a = 32'sd333772;
			5'd12: a = 32'sd166886;
			5'd13: a = 32'sd83443;
			5'd14: a = 32'sd41722;
			5'd15: a = 32'sd20861;
			5'd16: a = 32'sd10430;
			5'd17: a = 32'sd5215;
			5'd18: a = 32'sd2608;
			5'd19: a = 32'sd1304;
			5'd20: a = 32'sd652;
			5'd21: a = 32'sd326;
			5'd22: a = 32'sd163;
			5'd23: a = 32'sd81;
			5'd24: a = 32'sd41;
			5'd25: a = 32'sd20;
			5'd26: a = 32'sd10;
			5'd27: a = 32'sd5;
			5'd28: a = 32'sd3;
			5'd29: a = 32'sd1;
			default: a = '0;
		endcase
		return a;
	endfunction

	// Q60 to output format: round half up, then saturate
	function automatic q15_t to_out(input prod_t q);
		prod_t v;
		q15_t  r;
		v = (q + OUT_HALF) >>> OUT_SHIFT;
		if (v > OUT_MAX) begin
			r = q15_t'(OUT_MAX);
		end else if (v < OUT_MIN) begin
			r = q15_t'(OUT_MIN);
		end else begin
			r = v[OUT_W-1:0];
		end
		return r;
	endfunction

endpackage

>>> rtl/core/ete_if.sv
// Valid/ready channel interfaces for the angle input and quaternion output.
// Depends on ete_pkg for the field types.

interface ete_in_if;
	import ete_pkg::*;
	logic   valid;
	logic   ready;
	angle_t pitch_angle;
	angle_t yaw_angle;
	angle_t roll_angle;
	logic   angles_present;

	modport source(output valid, pitch_angle, yaw_angle, roll_angle, angles_present,
		input ready);
	modport sink(input valid, pitch_angle, yaw_angle, roll_angle, angles_present,
		output ready);
endinterface

interface ete_out_if;
	import ete_pkg::*;
	logic valid;
	logic ready;
	q15_t quat_x;
	q15_t quat_y;
	q15_t quat_z;
	q15_t quat_w;

	modport source(output valid, quat_x, quat_y, quat_z, quat_w, input ready);
	modport sink(input valid, quat_x, quat_y, quat_z, quat_w, output ready);
endinterface

>>> rtl/core/ete_cordic.sv
// Pipelined rotation-mode CORDIC: sine and cosine (Q30) of half a binary angle.
// One register stage for the quadrant setup, one per iteration. Uses ete_pkg.

module ete_cordic import ete_pkg::*; (
	input  logic    clk,
	input  logic    en,
	input  angle_t  angle,
	output sincos_t sc
);

	logic [31:0] h;
	sc_t   x_s [0:CORDIC_STEPS];
	sc_t   y_s [0:CORDIC_STEPS];
	zang_t z_s [0:CORDIC_STEPS-1];

	// half angle, 2^32 units per turn
	assign h = (32'(angle) & ANGLE_MASK) << HALF_SHIFT;

	always_ff @(posedge clk) begin
		if (en) begin
			// start past a quarter turn when the half angle is in the second quadrant
			if ($signed(h) >= QUARTER_TURN) begin
				x_s[0] <= '0;
				y_s[0] <= CORDIC_GAIN;
				z_s[0] <= $signed(h) - QUARTER_TURN;
			end else begin
				x_s[0] <= CORDIC_GAIN;
				y_s[0] <= '0;
				z_s[0] <= $signed(h);
			end
			for (int i = 0; i < CORDIC_STEPS; i++) begin
				if (!z_s[i][Z_W-1]) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
				end
				if (i < CORDIC_STEPS - 1) begin
					if (!z_s[i][Z_W-1]) begin
						z_s[i+1] <= z_s[i] - atan_turn(STEP_W'(i));
					end else begin
						z_s[i+1] <= z_s[i] + atan_turn(STEP_W'(i));
					end
				end
			end
		end
	end

	assign sc.s = y_s[CORDIC_STEPS];
	assign sc.c = x_s[CORDIC_STEPS];

endmodule

>>> rtl/core/euler_to_quaternion_unit.sv
// Top level: Euler angles (binary angles) to a Q1.15 unit quaternion.
// Depends on ete_pkg, ete_if (channels) and ete_cordic.
//
//  channel  dir  payload                                        handshake
//  angles   in   pitch/yaw/roll_angle (u16), angles_present     valid/ready
//  quat     out  quat_x/y/z/w (s16, Q1.15, saturated)           valid/ready
//
// One item per cycle unless the pipeline is frozen; 31 CORDIC stages, two
// stages for the pitch/yaw product and its rounding, two for the roll products
// and sums, one output register. The whole pipeline advances together; it
// freezes only while the output register holds a result that is not taken.
// Reset clears the valid bits; the data registers are not reset.

module euler_to_quaternion_unit import ete_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	ete_in_if.sink angles,
	ete_out_if.source quat
);

	logic adv;

	logic [CORDIC_LAT-1:0] vld_s;
	logic [CORDIC_LAT-1:0] pres_s;

	sincos_t sc_p, sc_y, sc_r;

	// pitch/yaw products
	logic  vld_s1, pres_s1;
	prod_t p0_s1, p1_s1, p2_s1, p3_s1;
	sc_t   sr_s1, cr_s1;
	// rounded intermediate quaternion
	logic  vld_s2, pres_s2;
	sc_t   t0_s2, t1_s2, t2_s2, t3_s2;
	sc_t   sr_s2, cr_s2;
	// roll products
	logic  vld_s3, pres_s3;
	prod_t srt3_s3, crt0_s3, crt1_s3, srt2_s3, crt2_s3, srt1_s3, crt3_s3, srt0_s3;
	// Q60 sums
	logic  vld_s4, pres_s4;
	prod_t x_s4, y_s4, z_s4, w_s4;
	// result register
	logic  out_vld_q;
	q15_t  x_q, y_q, z_q, w_q;

	assign adv          = !out_vld_q || quat.ready;
	assign angles.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s     <= '0;
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (adv) begin
			vld_s     <= {vld_s[CORDIC_LAT-2:0], angles.valid};
			vld_s1    <= vld_s[CORDIC_LAT-1];
			vld_s2    <= vld_s1;
			vld_s3    <= vld_s2;
			vld_s4    <= vld_s3;
			out_vld_q <= vld_s4;
		end
	end

	ete_cordic u_cordic_pitch (.clk(clk), .en(adv), .angle(angles.pitch_angle), .sc(sc_p));
	ete_cordic u_cordic_yaw   (.clk(clk), .en(adv), .angle(angles.yaw_angle),   .sc(sc_y));
	ete_cordic u_cordic_roll  (.clk(clk), .en(adv), .angle(angles.roll_angle),  .sc(sc_r));

	always_ff @(posedge clk) begin
		if (adv) begin
			pres_s <= {pres_s[CORDIC_LAT-2:0], angles.angles_present};

			pres_s1 <= pres_s[CORDIC_LAT-1];
			p0_s1   <= (-sc_p.s) * sc_y.s;
			p1_s1   <= sc_p.s * sc_y.c;
			p2_s1   <= sc_p.c * sc_y.s;
			p3_s1   <= sc_p.c * sc_y.c;
			sr_s1   <= sc_r.s;
			cr_s1   <= sc_r.c;

			pres_s2 <= pres_s1;
			t0_s2   <= SC_W'((p0_s1 + Q30_HALF) >>> Q30_SHIFT);
			t1_s2   <= SC_W'((p1_s1 + Q30_HALF) >>> Q30_SHIFT);
			t2_s2   <= SC_W'((p2_s1 + Q30_HALF) >>> Q30_SHIFT);
			t3_s2   <= SC_W'((p3_s1 + Q30_HALF) >>> Q30_SHIFT);
			sr_s2   <= sr_s1;
			cr_s2   <= cr_s1;

			pres_s3 <= pres_s2;
			srt3_s3 <= sr_s2 * t3_s2;
			crt0_s3 <= cr_s2 * t0_s2;
			crt1_s3 <= cr_s2 * t1_s2;
			srt2_s3 <= sr_s2 * t2_s2;
			crt2_s3 <= cr_s2 * t2_s2;
			srt1_s3 <= sr_s2 * t1_s2;
			crt3_s3 <= cr_s2 * t3_s2;
			srt0_s3 <= sr_s2 * t0_s2;

			pres_s4 <= pres_s3;
			x_s4    <= srt3_s3 + crt0_s3;
			y_s4    <= crt1_s3 + srt2_s3;
			z_s4    <= crt2_s3 - srt1_s3;
			w_s4    <= crt3_s3 - srt0_s3;

			// no angles: identity quaternion
			if (pres_s4) begin
				x_q <= to_out(x_s4);
				y_q <= to_out(y_s4);
				z_q <= to_out(z_s4);
				w_q <= to_out(w_s4);
			end else begin
				x_q <= '0;
				y_q <= '0;
				z_q <= '0;
				w_q <= IDENT_W;
			end
		end
	end

	assign quat.valid  = out_vld_q;
	assign quat.quat_x = x_q;
	assign quat.quat_y = y_q;
	assign quat.quat_z = z_q;
	assign quat.quat_w = w_q;

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		quat.valid && !quat.ready |-> !angles.ready)
		else $error("input taken while result register is stalled");

	a_transfer_enters: assert property (@(posedge clk) disable iff (!arst_n)
		angles.valid && angles.ready |=> vld_s[0])
		else $error("accepted transfer did not enter the pipeline");

	a_freeze_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vld_s) && $stable(vld_s4))
		else $error("pipeline moved while frozen");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(quat.valid) |-> $past(vld_s4))
		else $error("result appeared without an item in the last stage");

endmodule
